### hw/rtl/ptr_pkg.sv
// ----------------------------------------------------------------------------
// ptr_pkg: shared types and constants
// Carries the field widths, register indexes and queue entry type that the
// translation front end, the back end and the top level use.
// ----------------------------------------------------------------------------
package ptr_pkg;

	localparam int PageBits   = 3;
	localparam int OffsetBits = 11;
	localparam int AddrBits   = 14;
	localparam int PhysBits   = 27;
	localparam int CntBits    = 32;
	localparam int CfgBits    = 64;
	localparam int CfgIdxBits = 2;

	typedef enum logic [CfgIdxBits-1:0] {
		REG_REPLACE_MODE = 2'd0,
		REG_FRAME_COUNT  = 2'd1,
		REG_FRAMES_LOW   = 2'd2,
		REG_FRAMES_HIGH  = 2'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE  = 2'd0,
		ST_SWEEP = 2'd1,
		ST_FIFO  = 2'd2,
		ST_DONE  = 2'd3
	} back_state_t;

	// one classified item between front and back
	typedef struct packed {
		logic                  wr;
		logic [PageBits-1:0]   page;
		logic [OffsetBits-1:0] offset;
	} req_t;

endpackage

### hw/rtl/ptr_if.sv
// ----------------------------------------------------------------------------
// ptr_req_if / ptr_rsp_if: valid-ready channels
// Request and result channels of the translation block.
// ----------------------------------------------------------------------------
interface ptr_req_if;
	logic        valid;
	logic        ready;
	logic        cmd;
	logic [13:0] logical_address;

	modport source (output valid, cmd, logical_address, input ready);
	modport sink   (input valid, cmd, logical_address, output ready);
endinterface

interface ptr_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  page_index;
	logic [10:0] byte_offset;
	logic        page_fault;
	logic        write_back;
	logic [26:0] physical_address;
	logic [31:0] total_references;
	logic [31:0] total_reads;
	logic [31:0] total_writes;
	logic [31:0] total_faults;
	logic [31:0] total_write_backs;

	modport source (output valid, page_index, byte_offset, page_fault, write_back,
		physical_address, total_references, total_reads, total_writes,
		total_faults, total_write_backs, input ready);
	modport sink (input valid, page_index, byte_offset, page_fault, write_back,
		physical_address, total_references, total_reads, total_writes,
		total_faults, total_write_backs, output ready);
endinterface

### hw/rtl/paged_translation_with_replacement_core.sv
// ----------------------------------------------------------------------------
// paged_translation_with_replacement_core: page translation with replacement
// Top level: request queue, table back end and configuration port.
// ----------------------------------------------------------------------------
// Usage:
//  req carries a read/write command and a 14-bit logical address; rsp
//  returns page, offset, fault and write-back flags, the physical address and
//  five wrapping 32-bit totals. One result per item, in order.
//  cfg_we/cfg_index/cfg_data write replace_mode (0), frame_count (1),
//  frames_low (2) and frames_high (3); frame writes reload the free list and
//  invalidate all pages. Write only while idle.
//  A hit or a fault with a free frame goes from idle to done, which pops the
//  item and registers its result. A fault with no free frame in load-order
//  mode pops one load-order entry per cycle until a valid page is found, and
//  sweeps when every queued page is stale; a clock sweep takes one entry per
//  cycle, up to two passes of 8. The back end handles one item at a time.
//  Reset loads four frames from zeroed registers in the first cycle after
//  reset. The two-entry queue keeps accepting items while a result waits, until
//  it is full; a stalled receiver holds the result and blocks the back end.
module paged_translation_with_replacement_core #(
	parameter int MAX_FRAMES = 8,
	parameter int FRAME_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data,
	ptr_req_if.sink     req,
	ptr_rsp_if.source   rsp
);
	import ptr_pkg::*;

	logic q_valid, q_pop;
	req_t q_head;

	ptr_front u_front (
		.clk, .arst_n,
		.in_valid (req.valid), .in_ready (req.ready),
		.in_cmd (req.cmd), .in_addr (req.logical_address),
		.q_valid, .q_pop, .q_head
	);

	ptr_back #(.MAX_FRAMES(MAX_FRAMES), .FRAME_BITS(FRAME_BITS)) u_back (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data,
		.q_valid, .q_pop, .q_head,
		.out_valid (rsp.valid), .out_ready (rsp.ready),
		.out_page (rsp.page_index), .out_offset (rsp.byte_offset),
		.out_fault (rsp.page_fault), .out_wb (rsp.write_back),
		.out_phys (rsp.physical_address),
		.out_refs (rsp.total_references), .out_reads (rsp.total_reads),
		.out_writes (rsp.total_writes), .out_faults (rsp.total_faults),
		.out_wbs (rsp.total_write_backs)
	);

	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.ready) |=> rsp.valid)
		else $error("result dropped while stalled");
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.ready) |=> $stable(rsp.total_references))
		else $error("result changed while stalled");
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> rsp.physical_address[10:0] == rsp.byte_offset)
		else $error("offset not carried to physical address");

endmodule

### hw/rtl/ptr_front.sv
// ----------------------------------------------------------------------------
// ptr_front: request intake and queue
// Splits the address into page and offset and holds up to two items for the
// back end.
// ----------------------------------------------------------------------------
module ptr_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic           in_cmd,
	input  logic [13:0]    in_addr,
	output logic           q_valid,
	input  logic           q_pop,
	output ptr_pkg::req_t  q_head
);
	import ptr_pkg::*;

	req_t       slot_q [2];
	logic       rd_q, wr_q;
	logic [1:0] cnt_q;
	logic       push;
	req_t       req;

	assign in_ready = (cnt_q != 2'd2);
	assign push     = in_valid && in_ready;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_head   = slot_q[rd_q];

	// classify the address
	always_comb begin
		req.wr     = in_cmd;
		req.page   = in_addr[AddrBits-1:OffsetBits];
		req.offset = in_addr[OffsetBits-1:0];
	end

	// hold queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (q_pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

	// store item
	always_ff @(posedge clk) begin
		if (push) slot_q[wr_q] <= req;
	end

	assert property (@(posedge clk) disable iff (!arst_n) q_pop |-> q_valid)
		else $error("pop from empty queue");
	assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("queue count overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2 && !q_pop) |=> cnt_q == 2'd2)
		else $error("full queue lost an item");

endmodule

### hw/rtl/ptr_back.sv
// ----------------------------------------------------------------------------
// ptr_back: table walk and replacement
// Looks up the page, picks a victim by clock sweep or load order when a fault
// finds no free frame, updates the tables and counters and presents one result.
// ----------------------------------------------------------------------------
module ptr_back #(
	parameter int MAX_FRAMES = 8,
	parameter int FRAME_BITS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [1:0]                 cfg_index,
	input  logic [63:0]                cfg_data,
	input  logic                       q_valid,
	output logic                       q_pop,
	input  ptr_pkg::req_t              q_head,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [2:0]                 out_page,
	output logic [10:0]                out_offset,
	output logic                       out_fault,
	output logic                       out_wb,
	output logic [26:0]                out_phys,
	output logic [31:0]                out_refs,
	output logic [31:0]                out_reads,
	output logic [31:0]                out_writes,
	output logic [31:0]                out_faults,
	output logic [31:0]                out_wbs
);
	import ptr_pkg::*;

	localparam int Pages   = 8;
	localparam int FcBits  = $clog2(MAX_FRAMES + 1);

	back_state_t state_q, state_d;

	logic                  mode_q;
	logic [3:0]            fcount_q;
	logic [63:0]           flow_q, fhigh_q;

	logic [Pages-1:0]      vld_q, refb_q, mod_q;
	logic [FRAME_BITS-1:0] frame_q [Pages];
	logic [FRAME_BITS-1:0] free_q [MAX_FRAMES];
	logic [FcBits-1:0]     free_cnt_q;
	logic [PageBits-1:0]   ord_q [Pages];
	logic [3:0]            ord_cnt_q;
	logic [31:0]           c_refs_q, c_reads_q, c_writes_q, c_faults_q, c_wbs_q;

	logic                  reload_q;
	logic                  pass_q;
	logic [PageBits-1:0]   scan_q;
	logic                  wb_q;
	logic                  fault_q;

	logic                  fifo_pop, vic_take, load_go;
	logic [PageBits-1:0]   vic_page;
	logic [3:0]            n_frames;

	// clamp the configured frame count
	always_comb begin
		if (fcount_q == 4'd0) n_frames = 4'd1;
		else if (fcount_q > 4'(MAX_FRAMES)) n_frames = 4'(MAX_FRAMES);
		else n_frames = fcount_q;
	end

	// next state and step controls
	always_comb begin
		state_d  = state_q;
		fifo_pop = 1'b0;
		vic_take = 1'b0;
		load_go  = 1'b0;
		vic_page = scan_q;
		q_pop    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (q_valid && !out_valid) begin
					if (vld_q[q_head.page]) state_d = ST_DONE;
					else if (free_cnt_q != '0) begin
						load_go = 1'b1;
						state_d = ST_DONE;
					end else if (mode_q && ord_cnt_q != 4'd0) state_d = ST_FIFO;
					else state_d = ST_SWEEP;
				end
			end
			ST_FIFO: begin
				if (ord_cnt_q == 4'd0) state_d = ST_SWEEP;
				else begin
					fifo_pop = 1'b1;
					vic_page = ord_q[0];
					if (vld_q[ord_q[0]]) begin
						vic_take = 1'b1;
						state_d  = ST_IDLE;
					end
				end
			end
			ST_SWEEP: begin
				vic_page = scan_q;
				if (!wb_q && vld_q[scan_q] && !refb_q[scan_q] && !fault_q) begin
					vic_take = 1'b1;
				end
				if (scan_q == 3'(Pages - 1)) begin
					if (fault_q || vic_take || pass_q) state_d = ST_IDLE;
				end
			end
			ST_DONE: begin
				q_pop   = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// hold configuration, tables, counters and the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= 1'b0;
			fcount_q   <= 4'd4;
			flow_q     <= '0;
			fhigh_q    <= '0;
			reload_q   <= 1'b1;
			vld_q      <= '0;
			refb_q     <= '0;
			mod_q      <= '0;
			free_cnt_q <= '0;
			ord_cnt_q  <= '0;
			c_refs_q   <= '0;
			c_reads_q  <= '0;
			c_writes_q <= '0;
			c_faults_q <= '0;
			c_wbs_q    <= '0;
			out_valid  <= 1'b0;
			pass_q     <= 1'b0;
			scan_q     <= '0;
			wb_q       <= 1'b0;
			fault_q    <= 1'b0;
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			if (cfg_we) begin
				unique case (cfg_reg_t'(cfg_index))
					REG_REPLACE_MODE: mode_q <= cfg_data[0];
					REG_FRAME_COUNT:  fcount_q <= cfg_data[3:0];
					REG_FRAMES_LOW:   flow_q <= cfg_data;
					REG_FRAMES_HIGH:  fhigh_q <= cfg_data;
					default: ;
				endcase
			end
			// reload in the cycle after any frame register write
			reload_q <= cfg_we && (cfg_reg_t'(cfg_index) != REG_REPLACE_MODE);
			if (reload_q) begin
				// refill free list from the registers
				vld_q      <= '0;
				ord_cnt_q  <= '0;
				free_cnt_q <= FcBits'(n_frames);
				for (int i = 0; i < MAX_FRAMES; i++) begin
					if (i < 4) free_q[i] <= FRAME_BITS'(flow_q[16*(i%4) +: 16]);
					else free_q[i] <= FRAME_BITS'(fhigh_q[16*(i%4) +: 16]);
				end
			end
			// sweep bookkeeping: fault_q marks a found victim in this pass
			if (state_q != ST_SWEEP && state_d == ST_SWEEP) begin
				scan_q  <= '0;
				pass_q  <= 1'b0;
				fault_q <= 1'b0;
			end else if (state_q == ST_SWEEP) begin
				refb_q[scan_q] <= 1'b0;
				if (vic_take) fault_q <= 1'b1;
				scan_q <= scan_q + 3'd1;
				if (scan_q == 3'(Pages - 1)) pass_q <= 1'b1;
			end
			if (state_q == ST_DONE) wb_q <= 1'b0;
			// drop the head of the load order
			if (fifo_pop) begin
				for (int i = 0; i < Pages - 1; i++) ord_q[i] <= ord_q[i+1];
				ord_q[Pages-1] <= '0;
				ord_cnt_q <= ord_cnt_q - 4'd1;
			end
			// evict victim to the free list (list is empty here)
			if (vic_take) begin
				wb_q       <= mod_q[vic_page];
				vld_q[vic_page] <= 1'b0;
				free_q[0]  <= frame_q[vic_page];
				free_cnt_q <= FcBits'(1);
			end
			// load page from free list head, then finish the item
			if (load_go) begin
				frame_q[q_head.page] <= free_q[0];
				for (int i = 0; i < MAX_FRAMES - 1; i++) free_q[i] <= free_q[i+1];
				free_q[MAX_FRAMES-1] <= '0;
				free_cnt_q <= free_cnt_q - FcBits'(1);
				vld_q[q_head.page]  <= 1'b1;
				mod_q[q_head.page]  <= 1'b0;
				fault_q <= 1'b1;
				if (mode_q && ord_cnt_q < 4'(Pages)) begin
					ord_q[ord_cnt_q[2:0]] <= q_head.page;
					ord_cnt_q <= ord_cnt_q + 4'd1;
				end
			end
			if (state_q == ST_IDLE && state_d == ST_DONE && !load_go) fault_q <= 1'b0;
			if (state_q == ST_DONE) begin
				refb_q[q_head.page] <= 1'b1;
				if (q_head.wr) mod_q[q_head.page] <= 1'b1;
				c_refs_q <= c_refs_q + 32'd1;
				if (q_head.wr) c_writes_q <= c_writes_q + 32'd1;
				else c_reads_q <= c_reads_q + 32'd1;
				if (fault_q) c_faults_q <= c_faults_q + 32'd1;
				if (fault_q && wb_q) c_wbs_q <= c_wbs_q + 32'd1;
				out_valid <= 1'b1;
				out_fault <= fault_q;
				out_wb    <= fault_q && wb_q;
				out_page  <= q_head.page;
				out_offset <= q_head.offset;
				out_phys  <= PhysBits'({frame_q[q_head.page], q_head.offset});
				out_refs  <= c_refs_q + 32'd1;
				out_reads <= q_head.wr ? c_reads_q : c_reads_q + 32'd1;
				out_writes <= q_head.wr ? c_writes_q + 32'd1 : c_writes_q;
				out_faults <= fault_q ? c_faults_q + 32'd1 : c_faults_q;
				out_wbs   <= (fault_q && wb_q) ? c_wbs_q + 32'd1 : c_wbs_q;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		vic_take |-> free_cnt_q == '0)
		else $error("victim evicted with free frames left");
	assert property (@(posedge clk) disable iff (!arst_n)
		load_go |-> free_cnt_q != '0)
		else $error("load from empty free list");
	assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> out_valid)
		else $error("item finished without a result");

endmodule
